// File: rtl/float_xor_leading_byte_packer_assert.svh
// assertion macros for the packer checker
`ifndef FLOAT_XOR_LEADING_BYTE_PACKER_ASSERT_SVH
`define FLOAT_XOR_LEADING_BYTE_PACKER_ASSERT_SVH

`define FXP_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

`define FXP_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// File: rtl/fxp_pkg.sv
`default_nettype none
package fxp_pkg;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW = 1;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef enum logic [0:0] {
    REG_REQ_LEN = 1'b0,
    REG_MEDIAN  = 1'b1
  } reg_idx_t;

  // front-to-back item: float difference plus per-item config
  typedef struct packed {
    logic [31:0] diff;
    logic        start;
    logic [2:0]  shift;
    logic [2:0]  req_bytes;
  } fxp_item_t;

  // IEEE single subtract a - b, round to nearest even
  function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb, sx, sy, sr;
    logic [7:0]  ea, eb, ex, ey;
    logic [22:0] ma, mb;
    logic        nana, nanb, infa, infb;
    logic [26:0] fx, fy, fys;
    logic [7:0]  d;
    logic [27:0] sum;
    logic [4:0]  lz;
    logic [9:0]  e;
    logic [27:0] n;
    logic        st, g, r, s2, lsb, inc;
    logic [24:0] mr;
    logic [31:0] res;
    sa = a[31]; ea = a[30:23]; ma = a[22:0];
    sb = ~b[31]; eb = b[30:23]; mb = b[22:0];
    nana = (ea == 8'hFF) && (ma != 0);
    nanb = (eb == 8'hFF) && (mb != 0);
    infa = (ea == 8'hFF) && (ma == 0);
    infb = (eb == 8'hFF) && (mb == 0);
    res = 32'd0;
    if (nana || nanb || (infa && infb && (sa != sb))) begin
      res = CANON_NAN;
    end else if (infa) begin
      res = {sa, 8'hFF, 23'd0};
    end else if (infb) begin
      res = {sb, 8'hFF, 23'd0};
    end else begin
      if ({ea, ma} >= {eb, mb}) begin
        sx = sa; ex = ea; fx = {(ea != 0), ma, 3'b000};
        sy = sb; ey = eb; fy = {(eb != 0), mb, 3'b000};
      end else begin
        sx = sb; ex = eb; fx = {(eb != 0), mb, 3'b000};
        sy = sa; ey = ea; fy = {(ea != 0), ma, 3'b000};
      end
      if (ex == 0) ex = 8'd1;
      if (ey == 0) ey = 8'd1;
      d = ex - ey;
      if (d > 8'd26) begin
        fys = {26'd0, (fy != 0)};
      end else begin
        fys = fy >> d;
        st = ((fy & ((27'd1 << d) - 27'd1)) != 0);
        fys[0] = fys[0] | st;
      end
      if (sx == sy) sum = {1'b0, fx} + {1'b0, fys};
      else sum = {1'b0, fx} - {1'b0, fys};
      sr = sx;
      if (sum == 0) begin
        res = {(sa & sb), 31'd0};
      end else begin
        lz = 5'd0;
        for (int i = 27; i >= 0; i--) begin
          if (sum[i] && lz == 0 && (sum >> (i + 1)) == 0) lz = 5'(27 - i);
        end
        if (sum[27]) begin
          n = {1'b0, sum[27:1]};
          n[0] = n[0] | sum[0];
          e = {2'b00, ex} + 10'd1;
        end else begin
          if ({2'b00, ex} > {5'd0, lz} - 10'd1 + 10'd1 - 10'd1 + 10'd0 &&
              ({2'b00, ex} - 10'd1) >= ({5'd0, lz} - 10'd1)) begin
            n = sum << (lz - 5'd1);
            e = {2'b00, ex} - ({5'd0, lz} - 10'd1);
          end else begin
            n = sum << (ex - 8'd1);
            e = 10'd0;
          end
        end
        if (e != 0 && n[26] == 1'b0) e = 10'd0;
        lsb = n[3]; g = n[2]; r = n[1]; s2 = n[0];
        inc = g && (r || s2 || lsb);
        mr = {1'b0, n[26:3]} + {24'd0, inc};
        if (mr[24]) begin
          mr = mr >> 1;
          e = e + 10'd1;
        end else if (e == 0 && mr[23]) begin
          e = 10'd1;
        end
        if (e >= 10'd255) res = {sr, 8'hFF, 23'd0};
        else res = {sr, e[7:0], mr[22:0]};
      end
    end
    return res;
  endfunction
endpackage
`default_nettype wire

// File: rtl/fxp_front.sv
`default_nettype none
module fxp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_idx,
  input  wire logic [31:0]      cfg_data,
  input  wire logic             in_v,
  output logic                  in_rdy,
  input  wire logic [31:0]      in_sample,
  input  wire logic             in_start,
  output logic                  fr_v,
  input  wire logic             fr_rdy,
  output fxp_pkg::fxp_item_t    fr_item
);
  import fxp_pkg::*;
  logic [5:0]  len_r;
  logic [31:0] med_r;
  logic [5:0]  len_c;
  logic        v_r;
  fxp_item_t   item_r, item_nxt;

  assign len_c = (len_r == 0) ? 6'd1 : (len_r > 6'd32) ? 6'd32 : len_r;
  assign in_rdy = !v_r || fr_rdy;
  assign fr_v = v_r;
  assign fr_item = item_r;

  always_comb begin
    item_nxt.diff = fsub(in_sample, med_r);
    item_nxt.start = in_start;
    item_nxt.shift = (len_c[2:0] == 0) ? 3'd0 : 3'(4'd8 - {1'b0, len_c[2:0]});
    item_nxt.req_bytes = 3'((len_c + 6'd7) >> 3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 6'd32;
      med_r <= 32'd0;
      v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_REQ_LEN) len_r <= cfg_data[5:0];
        else med_r <= cfg_data;
      end
      if (in_rdy) v_r <= in_v;
    end
    if (in_rdy && in_v) item_r <= item_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/fxp_queue.sv
`default_nettype none
module fxp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_v,
  output logic                  wr_rdy,
  input  wire fxp_pkg::fxp_item_t wr_item,
  output logic                  rd_v,
  input  wire logic             rd_rdy,
  output fxp_pkg::fxp_item_t    rd_item
);
  import fxp_pkg::*;
  fxp_item_t mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic wr, rd;
  assign wr_rdy = cnt_r != (QAW+1)'(QDEPTH);
  assign rd_v = cnt_r != 0;
  assign rd_item = mem[rp_r];
  assign wr = wr_v && wr_rdy;
  assign rd = rd_v && rd_rdy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
    if (wr) mem[wp_r] <= wr_item;
  end
endmodule
`default_nettype wire

// File: rtl/fxp_back.sv
`default_nettype none
module fxp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             bk_v,
  output logic                  bk_rdy,
  input  wire fxp_pkg::fxp_item_t bk_item,
  output logic                  out_v,
  input  wire logic             out_rdy,
  output logic [1:0]            out_lead,
  output logic [2:0]            out_cnt,
  output logic [31:0]           out_res
);
  import fxp_pkg::*;
  logic [31:0] prev_r, cur, x, res_nxt;
  logic [1:0]  lead, lead_r;
  logic [2:0]  cnt, cnt_r;
  logic [31:0] res_r;
  logic        v_r;
  logic [1:0]  idx;

  assign bk_rdy = !v_r || out_rdy;
  assign out_v = v_r;
  assign out_lead = lead_r;
  assign out_cnt = cnt_r;
  assign out_res = res_r;

  always_comb begin
    cur = bk_item.diff >> bk_item.shift;
    x = cur ^ (bk_item.start ? 32'd0 : prev_r);
    if (x[31:8] == 0) lead = 2'd3;
    else if (x[31:16] == 0) lead = 2'd2;
    else if (x[31:24] == 0) lead = 2'd1;
    else lead = 2'd0;
    cnt = (bk_item.req_bytes > {1'b0, lead}) ? bk_item.req_bytes - {1'b0, lead} : 3'd0;
    res_nxt = 32'd0;
    for (int k = 0; k < 4; k++) begin
      idx = 2'(3'd4 - bk_item.req_bytes + 3'(k));
      if (3'(k) < cnt) res_nxt[8*k +: 8] = cur[8*idx +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      prev_r <= 32'd0;
    end else begin
      if (bk_rdy) v_r <= bk_v;
      if (bk_rdy && bk_v) prev_r <= cur;
    end
    if (bk_rdy && bk_v) begin
      lead_r <= lead; cnt_r <= cnt; res_r <= res_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/float_xor_leading_byte_packer.sv
// channel | dir | tdata (low bit up)                       | tuser
// in_     | in  | sample_bits[31:0]                        | block_start
// out_    | out | residual_bytes[31:0]                     | lead_count[1:0], byte_count[4:2]
// cfg_    | in  | write: idx 0 required_length, 1 median_bits
// One sample per cycle unless the out side stalls; path: front register, queue, back register.
// Float subtract sits in the front stage, byte packing in the back stage,
// with a two-entry queue between them.
// Synchronous active-low reset sets config to length 32, median 0, clears previous pattern and valids.
// Stalls on the out side fill the queue, then drop in_tready.
`default_nettype none
module float_xor_leading_byte_packer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // sample_bits
  input  wire logic        in_tuser,  // block_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // residual_bytes
  output logic [4:0]       out_tuser  // lead_count, byte_count
);
  import fxp_pkg::*;
  logic fv, frdy, bv, brdy;
  fxp_item_t fi, bi;
  logic [1:0] lead;
  logic [2:0] cnt;
  fxp_front u_front (.clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .in_v(in_tvalid),
    .in_rdy(in_tready), .in_sample(in_tdata), .in_start(in_tuser), .fr_v(fv),
    .fr_rdy(frdy), .fr_item(fi));
  fxp_queue u_q (.clk, .rst_n, .wr_v(fv), .wr_rdy(frdy), .wr_item(fi), .rd_v(bv),
    .rd_rdy(brdy), .rd_item(bi));
  fxp_back u_back (.clk, .rst_n, .bk_v(bv), .bk_rdy(brdy), .bk_item(bi),
    .out_v(out_tvalid), .out_rdy(out_tready), .out_lead(lead), .out_cnt(cnt),
    .out_res(out_tdata));
  assign out_tuser = {cnt, lead};
endmodule
`default_nettype wire

// File: rtl/fxp_checker.sv
`default_nettype none
`include "float_xor_leading_byte_packer_assert.svh"
module fxp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [4:0]  out_tuser
);
  `FXP_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `FXP_ASSERT_IMP(a_cnt, clk, rst_n, out_tvalid, out_tuser[4:2] <= 3'd4)
  `FXP_ASSERT_IMP(a_zero, clk, rst_n, out_tvalid && out_tuser[4:2] == 3'd0, out_tdata == 32'd0)
  `FXP_ASSERT_IMP(a_rdy, clk, rst_n, out_tready && !out_tvalid, in_tready)
endmodule
bind float_xor_leading_byte_packer fxp_checker u_chk (.*);
`default_nettype wire
